// ===== rtl/otl_pkg.sv =====
package otl_pkg;

    localparam int ChWidth   = 8;
    localparam int CodeWidth = 6;
    localparam int QDepth    = 3;
    localparam int CntWidth  = $clog2(QDepth + 1);

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_TOKEN  = 2'd0,
        KIND_REJECT = 2'd1,
        KIND_ERROR  = 2'd2
    } t_kind;

    // Pending operator prefix.
    typedef enum logic [4:0] {
        P_NONE   = 5'd0,
        P_LT     = 5'd1,
        P_SHL    = 5'd2,
        P_GT     = 5'd3,
        P_SHR    = 5'd4,
        P_ASSIGN = 5'd5,
        P_NOT    = 5'd6,
        P_AMP    = 5'd7,
        P_BAR    = 5'd8,
        P_CARET  = 5'd9,
        P_STAR   = 5'd10,
        P_SLASH  = 5'd11,
        P_PLUS   = 5'd12,
        P_MINUS  = 5'd13,
        P_PCT    = 5'd14,
        P_DOT    = 5'd15,
        P_DOTDOT = 5'd16,
        P_COLON  = 5'd17
    } t_prefix;

    // Token codes in table order.
    localparam logic [CodeWidth-1:0] T_NONE     = 6'd0;
    localparam logic [CodeWidth-1:0] T_LBRACK   = 6'd1;
    localparam logic [CodeWidth-1:0] T_RBRACK   = 6'd2;
    localparam logic [CodeWidth-1:0] T_LPAREN   = 6'd3;
    localparam logic [CodeWidth-1:0] T_RPAREN   = 6'd4;
    localparam logic [CodeWidth-1:0] T_LBRACE   = 6'd5;
    localparam logic [CodeWidth-1:0] T_RBRACE   = 6'd6;
    localparam logic [CodeWidth-1:0] T_LT       = 6'd7;
    localparam logic [CodeWidth-1:0] T_LE       = 6'd8;
    localparam logic [CodeWidth-1:0] T_SHL      = 6'd9;
    localparam logic [CodeWidth-1:0] T_SHL_EQ   = 6'd10;
    localparam logic [CodeWidth-1:0] T_GT       = 6'd11;
    localparam logic [CodeWidth-1:0] T_GE       = 6'd12;
    localparam logic [CodeWidth-1:0] T_SHR      = 6'd13;
    localparam logic [CodeWidth-1:0] T_SHR_EQ   = 6'd14;
    localparam logic [CodeWidth-1:0] T_ASSIGN   = 6'd15;
    localparam logic [CodeWidth-1:0] T_EQ       = 6'd16;
    localparam logic [CodeWidth-1:0] T_NOT      = 6'd17;
    localparam logic [CodeWidth-1:0] T_NE       = 6'd18;
    localparam logic [CodeWidth-1:0] T_AMP      = 6'd19;
    localparam logic [CodeWidth-1:0] T_AMP_EQ   = 6'd20;
    localparam logic [CodeWidth-1:0] T_LAND     = 6'd21;
    localparam logic [CodeWidth-1:0] T_BAR      = 6'd22;
    localparam logic [CodeWidth-1:0] T_BAR_EQ   = 6'd23;
    localparam logic [CodeWidth-1:0] T_LOR      = 6'd24;
    localparam logic [CodeWidth-1:0] T_CARET    = 6'd25;
    localparam logic [CodeWidth-1:0] T_CARET_EQ = 6'd26;
    localparam logic [CodeWidth-1:0] T_TILDE    = 6'd27;
    localparam logic [CodeWidth-1:0] T_STAR     = 6'd28;
    localparam logic [CodeWidth-1:0] T_POW      = 6'd29;
    localparam logic [CodeWidth-1:0] T_STAR_EQ  = 6'd30;
    localparam logic [CodeWidth-1:0] T_SLASH    = 6'd31;
    localparam logic [CodeWidth-1:0] T_SLASH_EQ = 6'd32;
    localparam logic [CodeWidth-1:0] T_PLUS     = 6'd33;
    localparam logic [CodeWidth-1:0] T_PLUS_EQ  = 6'd34;
    localparam logic [CodeWidth-1:0] T_INC      = 6'd35;
    localparam logic [CodeWidth-1:0] T_MINUS    = 6'd36;
    localparam logic [CodeWidth-1:0] T_MINUS_EQ = 6'd37;
    localparam logic [CodeWidth-1:0] T_DEC      = 6'd38;
    localparam logic [CodeWidth-1:0] T_ARROW    = 6'd39;
    localparam logic [CodeWidth-1:0] T_PCT      = 6'd40;
    localparam logic [CodeWidth-1:0] T_PCT_EQ   = 6'd41;
    localparam logic [CodeWidth-1:0] T_COMMA    = 6'd42;
    localparam logic [CodeWidth-1:0] T_DOT      = 6'd43;
    localparam logic [CodeWidth-1:0] T_ELLIPSIS = 6'd44;
    localparam logic [CodeWidth-1:0] T_COLON    = 6'd45;
    localparam logic [CodeWidth-1:0] T_SCOPE    = 6'd46;
    localparam logic [CodeWidth-1:0] T_SEMI     = 6'd47;
    localparam logic [CodeWidth-1:0] T_QUEST    = 6'd48;
    localparam logic [CodeWidth-1:0] T_PCT_LBR  = 6'd49;
    localparam logic [CodeWidth-1:0] T_PCT_RBR  = 6'd50;
    localparam logic [CodeWidth-1:0] T_PCT_PCT  = 6'd51;

    typedef struct packed {
        t_kind                kind;
        logic [CodeWidth-1:0] code;
        logic                 last;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
        t_prefix    next;
    } t_step;

    typedef struct packed {
        logic                 emit;
        t_kind                kind;
        logic [CodeWidth-1:0] code;
        t_prefix              next;
    } t_begin;

    // Token emitted when a prefix closes without being extended.
    function automatic logic [CodeWidth-1:0] flush_code(input t_prefix p);
        logic [CodeWidth-1:0] code;
        case (p)
            P_LT:     code = T_LT;
            P_SHL:    code = T_SHL;
            P_GT:     code = T_GT;
            P_SHR:    code = T_SHR;
            P_ASSIGN: code = T_ASSIGN;
            P_NOT:    code = T_NOT;
            P_AMP:    code = T_AMP;
            P_BAR:    code = T_BAR;
            P_CARET:  code = T_CARET;
            P_STAR:   code = T_STAR;
            P_SLASH:  code = T_SLASH;
            P_PLUS:   code = T_PLUS;
            P_MINUS:  code = T_MINUS;
            P_PCT:    code = T_PCT;
            P_DOT:    code = T_DOT;
            P_COLON:  code = T_COLON;
            default:  code = T_NONE;
        endcase
        return code;
    endfunction

    // A character met with nothing pending.
    function automatic t_begin start_char(input logic [ChWidth-1:0] c);
        t_begin b;
        b.code = T_NONE;
        b.next = P_NONE;
        case (c)
            "[":     b.code = T_LBRACK;
            "]":     b.code = T_RBRACK;
            "(":     b.code = T_LPAREN;
            ")":     b.code = T_RPAREN;
            "{":     b.code = T_LBRACE;
            "}":     b.code = T_RBRACE;
            "~":     b.code = T_TILDE;
            ",":     b.code = T_COMMA;
            ";":     b.code = T_SEMI;
            "?":     b.code = T_QUEST;
            "<":     b.next = P_LT;
            ">":     b.next = P_GT;
            "=":     b.next = P_ASSIGN;
            "!":     b.next = P_NOT;
            "&":     b.next = P_AMP;
            "|":     b.next = P_BAR;
            "^":     b.next = P_CARET;
            "*":     b.next = P_STAR;
            "/":     b.next = P_SLASH;
            "+":     b.next = P_PLUS;
            "-":     b.next = P_MINUS;
            "%":     b.next = P_PCT;
            ".":     b.next = P_DOT;
            ":":     b.next = P_COLON;
            default: b.next = P_NONE;
        endcase
        b.emit = (b.code != T_NONE) || (b.next == P_NONE);
        b.kind = (b.code != T_NONE) ? KIND_TOKEN : KIND_REJECT;
        return b;
    endfunction

    // One character (or end of text) against the pending prefix.
    function automatic t_step lex_step(input t_prefix p, input logic [ChWidth-1:0] c,
                                       input logic eot);
        t_step                s;
        t_begin               b;
        logic                 take;
        logic                 reject;
        logic                 drop;
        logic [CodeWidth-1:0] code;
        t_prefix              np;
        take   = 1'b0;
        reject = 1'b0;
        drop   = 1'b0;
        code   = T_NONE;
        np     = P_NONE;
        b      = start_char(c);
        s      = '0;
        s.next = P_NONE;

        case (p)
            P_LT: begin
                if (c == "<") begin np = P_SHL; take = 1'b1; end
                else if (c == "=") begin code = T_LE; take = 1'b1; end
            end
            P_SHL:    if (c == "=") begin code = T_SHL_EQ; take = 1'b1; end
            P_GT: begin
                if (c == ">") begin np = P_SHR; take = 1'b1; end
                else if (c == "=") begin code = T_GE; take = 1'b1; end
            end
            P_SHR:    if (c == "=") begin code = T_SHR_EQ; take = 1'b1; end
            P_ASSIGN: if (c == "=") begin code = T_EQ; take = 1'b1; end
            P_NOT:    if (c == "=") begin code = T_NE; take = 1'b1; end
            P_CARET:  if (c == "=") begin code = T_CARET_EQ; take = 1'b1; end
            P_AMP: begin
                if (c == "&") begin code = T_LAND; take = 1'b1; end
                else if (c == "=") begin code = T_AMP_EQ; take = 1'b1; end
            end
            P_BAR: begin
                if (c == "|") begin code = T_LOR; take = 1'b1; end
                else if (c == "=") begin code = T_BAR_EQ; take = 1'b1; end
            end
            P_STAR: begin
                if (c == "*") begin code = T_POW; take = 1'b1; end
                else if (c == "=") begin code = T_STAR_EQ; take = 1'b1; end
            end
            P_SLASH: begin
                if (c == "=") begin code = T_SLASH_EQ; take = 1'b1; end
                else if (c == "/" || c == "*") reject = 1'b1;
            end
            P_PLUS: begin
                if (c == "+") begin code = T_INC; take = 1'b1; end
                else if (c == "=") begin code = T_PLUS_EQ; take = 1'b1; end
            end
            P_MINUS: begin
                if (c == "-") begin code = T_DEC; take = 1'b1; end
                else if (c == "=") begin code = T_MINUS_EQ; take = 1'b1; end
                else if (c == ">") begin code = T_ARROW; take = 1'b1; end
            end
            P_PCT: begin
                if (c == "=") begin code = T_PCT_EQ; take = 1'b1; end
                else if (c == "{") begin code = T_PCT_LBR; take = 1'b1; end
                else if (c == "}") begin code = T_PCT_RBR; take = 1'b1; end
                else if (c == "%") begin code = T_PCT_PCT; take = 1'b1; end
            end
            P_DOT: begin
                if (c == ".") begin np = P_DOTDOT; take = 1'b1; end
                else if (c inside {["0":"9"]}) reject = 1'b1;
            end
            P_DOTDOT: begin
                if (c == ".") begin code = T_ELLIPSIS; take = 1'b1; end
                else drop = 1'b1;
            end
            P_COLON:  if (c == ":") begin code = T_SCOPE; take = 1'b1; end
            default:  take = 1'b0;
        endcase

        if (eot) begin
            // Flush whatever is pending; a lone pair of periods is an error.
            if (p == P_DOTDOT) begin
                s.count = 2'd1;
                s.res0  = '{kind: KIND_ERROR, code: T_NONE, last: 1'b1};
            end else if (p != P_NONE) begin
                s.count = 2'd1;
                s.res0  = '{kind: KIND_TOKEN, code: flush_code(p), last: 1'b1};
            end
        end else if (take) begin
            s.next = np;
            if (code != T_NONE) begin
                s.count = 2'd1;
                s.res0  = '{kind: KIND_TOKEN, code: code, last: 1'b1};
            end
        end else if (drop) begin
            s.count = 2'd1;
            s.res0  = '{kind: KIND_ERROR, code: T_NONE, last: 1'b1};
        end else begin
            // The pending prefix closes (as a reject or as its own token) and
            // the character then starts afresh.
            s.next = b.next;
            if (reject || p != P_NONE) begin
                s.res0.kind = reject ? KIND_REJECT : KIND_TOKEN;
                s.res0.code = reject ? T_NONE : flush_code(p);
                s.res0.last = !b.emit;
                s.res1      = '{kind: b.kind, code: b.code, last: 1'b1};
                s.count     = b.emit ? 2'd2 : 2'd1;
            end else if (b.emit) begin
                s.count = 2'd1;
                s.res0  = '{kind: b.kind, code: b.code, last: 1'b1};
            end
        end
        return s;
    endfunction

endpackage

// ===== rtl/operator_token_lexer.sv =====
// Operator lexer: one text character per input beat, longest-match C operators.
// The results of an accepted beat are registered in the result queue, whose head
// drives the master side. Throughput: one character per cycle while the master
// side keeps pace; a character that yields two results holds the next beat off,
// set by the single output port. Reset (i_rst_n low at a clock edge) empties the
// result queue and clears the pending prefix.
module operator_token_lexer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Slave side: one character per beat.
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tuser,   // [0] end_of_text
    // Master side: one result per beat.
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] kind, [7:2] token_code
    output logic       m_tlast    // last result caused by the character
);

    import otl_pkg::*;

    // The pending prefix is the only lexer state. All the work for a beat is
    // done by lex_step in one pass; its results, up to two, go straight into a
    // small result queue whose head drives the master side.
    t_prefix           r_prefix;
    t_prefix           n_prefix;
    t_res              r_q [QDepth];
    t_res              n_q [QDepth];
    logic [CntWidth-1:0] r_count;
    logic [CntWidth-1:0] n_count;
    logic [CntWidth-1:0] base;
    t_step             step;
    logic              push;
    logic              pop;

    // Three entries: with at most one waiting, a beat that gives two results
    // still fits, so ready depends on registered state only; one beat per cycle
    // flows while the downstream side keeps pace and no beat gives two results.
    assign s_tready = (r_count <= CntWidth'(1));
    assign push     = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    assign m_tvalid = (r_count != '0);
    assign m_tdata  = {r_q[0].code, r_q[0].kind};
    assign m_tlast  = r_q[0].last;

    assign step = lex_step(r_prefix, s_tdata, s_tuser);
    assign base = r_count - CntWidth'(pop);

    always_comb begin
        n_prefix = push ? step.next : r_prefix;
        n_count  = base + (push ? CntWidth'(step.count) : '0);
        for (int i = 0; i < QDepth; i++) begin
            // Shift the queue down as the head leaves, then append new results.
            if (pop && i < QDepth - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push && step.count != 2'd0 && CntWidth'(i) == base) begin
                n_q[i] = step.res0;
            end
            if (push && step.count == 2'd2 && CntWidth'(i) == base + CntWidth'(1)) begin
                n_q[i] = step.res1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefix <= P_NONE;
            r_count  <= '0;
        end else begin
            r_prefix <= n_prefix;
            r_count  <= n_count;
        end
    end

    // Queue payload needs no reset; the count says which entries hold data.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QDepth; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the operator lexer. Characters go in one per beat on
// the slave side; each accepted beat is run through a behavioural lexer kept in
// this module, which queues the results that beat must produce. Every result
// beat taken from the master side is compared with the oldest queued entry.
module tb_top;

    import otl_pkg::*;

    localparam int CycleLimit = 200000;

    // One expected result beat.
    typedef struct {
        t_kind                kind;
        logic [CodeWidth-1:0] code;
        logic                 last;
    } t_lex_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] ch
    logic       s_tuser;   // [0] end_of_text
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [1:0] kind, [7:2] token_code
    logic       m_tlast;

    // Prefix held by the behavioural lexer, and the results still owed.
    t_prefix     lex_state;
    t_lex_result tokens_due[$];

    int mismatches  = 0;
    int results_got = 0;
    int chars_fed   = 0;
    int cycle_count = 0;

    // Idle rates (per cent) of the two sides and the receiver's hold-off.
    int tx_idle_pct = 24;
    int rx_idle_pct = 24;
    int rx_hold     = 0;

    // Every operator spelled out, indexed by its token code.
    string op_spell [1:51] = '{
        "[", "]", "(", ")", "{", "}", "<", "<=", "<<", "<<=", ">", ">=", ">>",
        ">>=", "=", "==", "!", "!=", "&", "&=", "&&", "|", "|=", "||", "^",
        "^=", "~", "*", "**", "*=", "/", "/=", "+", "+=", "++", "-", "-=",
        "--", "->", "%", "%=", ",", ".", "...", ":", "::", ";", "?", "%{",
        "%}", "%%"
    };

    operator_token_lexer u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Behavioural lexer
    // ------------------------------------------------------------------

    // Token that a prefix stands for when nothing extends it. A pair of
    // periods has no token of its own.
    function automatic logic [CodeWidth-1:0] close_code(input t_prefix p);
        case (p)
            P_LT:     return T_LT;
            P_SHL:    return T_SHL;
            P_GT:     return T_GT;
            P_SHR:    return T_SHR;
            P_ASSIGN: return T_ASSIGN;
            P_NOT:    return T_NOT;
            P_AMP:    return T_AMP;
            P_BAR:    return T_BAR;
            P_CARET:  return T_CARET;
            P_STAR:   return T_STAR;
            P_SLASH:  return T_SLASH;
            P_PLUS:   return T_PLUS;
            P_MINUS:  return T_MINUS;
            P_PCT:    return T_PCT;
            P_DOT:    return T_DOT;
            P_COLON:  return T_COLON;
            default:  return T_NONE;
        endcase
    endfunction

    // Does character c carry prefix p further? If so, either a finished token
    // comes back in code or a longer prefix in np. Note that '%' extends
    // nothing but '%' itself.
    function automatic logic extends_prefix(input t_prefix p, input logic [7:0] c,
                                            output logic [CodeWidth-1:0] code,
                                            output t_prefix np);
        logic ok;
        ok   = 1'b1;
        code = T_NONE;
        np   = P_NONE;
        case (p)
            P_LT:     if (c == "<") np = P_SHL;
                      else if (c == "=") code = T_LE;
                      else ok = 1'b0;
            P_SHL:    if (c == "=") code = T_SHL_EQ; else ok = 1'b0;
            P_GT:     if (c == ">") np = P_SHR;
                      else if (c == "=") code = T_GE;
                      else ok = 1'b0;
            P_SHR:    if (c == "=") code = T_SHR_EQ; else ok = 1'b0;
            P_ASSIGN: if (c == "=") code = T_EQ; else ok = 1'b0;
            P_NOT:    if (c == "=") code = T_NE; else ok = 1'b0;
            P_CARET:  if (c == "=") code = T_CARET_EQ; else ok = 1'b0;
            P_AMP:    if (c == "&") code = T_LAND;
                      else if (c == "=") code = T_AMP_EQ;
                      else ok = 1'b0;
            P_BAR:    if (c == "|") code = T_LOR;
                      else if (c == "=") code = T_BAR_EQ;
                      else ok = 1'b0;
            P_STAR:   if (c == "*") code = T_POW;
                      else if (c == "=") code = T_STAR_EQ;
                      else ok = 1'b0;
            P_SLASH:  if (c == "=") code = T_SLASH_EQ; else ok = 1'b0;
            P_PLUS:   if (c == "+") code = T_INC;
                      else if (c == "=") code = T_PLUS_EQ;
                      else ok = 1'b0;
            P_MINUS:  if (c == "-") code = T_DEC;
                      else if (c == "=") code = T_MINUS_EQ;
                      else if (c == ">") code = T_ARROW;
                      else ok = 1'b0;
            P_PCT:    if (c == "=") code = T_PCT_EQ;
                      else if (c == "{") code = T_PCT_LBR;
                      else if (c == "}") code = T_PCT_RBR;
                      else if (c == "%") code = T_PCT_PCT;
                      else ok = 1'b0;
            P_DOT:    if (c == ".") np = P_DOTDOT; else ok = 1'b0;
            P_DOTDOT: if (c == ".") code = T_ELLIPSIS; else ok = 1'b0;
            P_COLON:  if (c == ":") code = T_SCOPE; else ok = 1'b0;
            default:  ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic void owe_result(input t_kind kind, input logic [CodeWidth-1:0] code);
        t_lex_result r;
        r.kind = kind;
        r.code = code;
        r.last = 1'b0;
        tokens_due.push_back(r);
    endfunction

    // A character met with nothing pending: a lone operator comes out at once,
    // an operator that may grow becomes the prefix, anything else is rejected.
    function automatic void start_afresh(input logic [7:0] c);
        lex_state = P_NONE;
        case (c)
            "[": owe_result(KIND_TOKEN, T_LBRACK);
            "]": owe_result(KIND_TOKEN, T_RBRACK);
            "(": owe_result(KIND_TOKEN, T_LPAREN);
            ")": owe_result(KIND_TOKEN, T_RPAREN);
            "{": owe_result(KIND_TOKEN, T_LBRACE);
            "}": owe_result(KIND_TOKEN, T_RBRACE);
            "~": owe_result(KIND_TOKEN, T_TILDE);
            ",": owe_result(KIND_TOKEN, T_COMMA);
            ";": owe_result(KIND_TOKEN, T_SEMI);
            "?": owe_result(KIND_TOKEN, T_QUEST);
            "<": lex_state = P_LT;
            ">": lex_state = P_GT;
            "=": lex_state = P_ASSIGN;
            "!": lex_state = P_NOT;
            "&": lex_state = P_AMP;
            "|": lex_state = P_BAR;
            "^": lex_state = P_CARET;
            "*": lex_state = P_STAR;
            "/": lex_state = P_SLASH;
            "+": lex_state = P_PLUS;
            "-": lex_state = P_MINUS;
            "%": lex_state = P_PCT;
            ".": lex_state = P_DOT;
            ":": lex_state = P_COLON;
            default: owe_result(KIND_REJECT, T_NONE);
        endcase
    endfunction

    // Works out the result beats owed for one accepted character beat.
    function automatic void lex_predict(input logic [7:0] c, input logic eot);
        int                   q0;
        t_prefix              p;
        t_prefix              np;
        logic [CodeWidth-1:0] code;
        t_lex_result          tail;
        q0 = tokens_due.size();
        p  = lex_state;
        if (eot) begin
            // End of text: flush what is pending; a lone pair of periods
            // cannot stand on its own.
            if (p == P_DOTDOT)
                owe_result(KIND_ERROR, T_NONE);
            else if (p != P_NONE)
                owe_result(KIND_TOKEN, close_code(p));
            lex_state = P_NONE;
        end else if (extends_prefix(p, c, code, np)) begin
            if (code != T_NONE)
                owe_result(KIND_TOKEN, code);
            lex_state = np;
        end else if (p == P_DOTDOT) begin
            // Two periods then something else: error, and the character
            // is swallowed.
            owe_result(KIND_ERROR, T_NONE);
            lex_state = P_NONE;
        end else begin
            // A slash opening a comment, or a period opening a number, is
            // rejected rather than emitted; the character is then taken anew.
            if ((p == P_SLASH && (c == "/" || c == "*")) ||
                (p == P_DOT && c >= "0" && c <= "9"))
                owe_result(KIND_REJECT, T_NONE);
            else if (p != P_NONE)
                owe_result(KIND_TOKEN, close_code(p));
            start_afresh(c);
        end
        if (tokens_due.size() > q0) begin
            tail      = tokens_due.pop_back();
            tail.last = 1'b1;
            tokens_due.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_got, msg);
        mismatches++;
    endtask

    // The receiver is ready at random, except during a hold-off, which it
    // counts down itself.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                m_tready = 1'b0;
                rx_hold--;
            end else begin
                m_tready = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Each result beat is compared field by field with the oldest owed entry.
    always @(posedge i_clk) begin
        t_lex_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (tokens_due.size() == 0) begin
                report_mismatch($sformatf("result beat with nothing owed: kind %0d code %0d",
                                          m_tdata[1:0], m_tdata[7:2]));
            end else begin
                want = tokens_due.pop_front();
                if (m_tdata[1:0] !== want.kind)
                    report_mismatch($sformatf("kind got %0d, want %0d",
                                              m_tdata[1:0], want.kind));
                if (m_tdata[7:2] !== want.code)
                    report_mismatch($sformatf("token_code got %0d, want %0d",
                                              m_tdata[7:2], want.code));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last got %0d, want %0d",
                                              m_tlast, want.last));
            end
            results_got++;
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------

    // Offers one beat, after a random gap, and predicts once it is taken.
    // Called and returns at a falling edge.
    task automatic feed_char(input logic [7:0] c, input logic eot);
        while ($urandom_range(99) < tx_idle_pct)
            @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tuser  = eot;
        do
            @(posedge i_clk);
        while (s_tready !== 1'b1);
        lex_predict(c, eot);
        chars_fed++;
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic feed_text(input string s);
        for (int i = 0; i < s.len(); i++)
            feed_char(s[i], 1'b0);
    endtask

    // The character lane carries noise on end-of-text beats.
    task automatic feed_eot();
        feed_char(8'($urandom_range(255)), 1'b1);
    endtask

    // A random spelling of any operator.
    task automatic feed_operator();
        feed_text(op_spell[$urandom_range(51, 1)]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extreme bytes, neither of them an operator character.
    task automatic test_byte_extremes();
        feed_char(8'h00, 1'b0);
        feed_char(8'hFF, 1'b0);
    endtask

    // A slash that opens a comment is rejected; the character after it then
    // starts afresh as a prefix of its own.
    task automatic test_comment_openers();
        feed_text("//");
        feed_text("/*");
        feed_eot();
    endtask

    // A period before a digit, two periods before something else, the full
    // ellipsis, and two periods at the end of the text.
    task automatic test_periods();
        feed_text(".5");
        feed_text("..x");
        feed_text("...");
        feed_text("..");
        feed_eot();
    endtask

    // Flushing: a lone period, a lone slash, and nothing pending at all.
    task automatic test_end_of_text();
        feed_text(".");
        feed_eot();
        feed_text("/");
        feed_eot();
        feed_eot();
    endtask

    // '%' does not extend '=', but does extend '%'; three-character shifts.
    task automatic test_percent_and_shifts();
        feed_text("=%%");
        feed_text("<<=");
        feed_eot();
    endtask

    // Mostly well-formed operator text with random breaks and noise, so that
    // every prefix is reached and left in every way.
    task automatic test_random_text(input int n_chars);
        int    stop_at;
        int    pick;
        string partial;
        partial = "./*%=<>:-+&|!^09";
        stop_at = chars_fed + n_chars;
        while (chars_fed < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 55)
                feed_operator();
            else if (pick < 67)
                feed_char(8'($urandom_range(126, 32)), 1'b0);
            else if (pick < 80)
                feed_char(partial[$urandom_range(partial.len() - 1)], 1'b0);
            else if (pick < 94)
                feed_char(8'($urandom_range(255)), 1'b0);
            else
                feed_eot();
        end
    endtask

    // Both sides flat out: back-to-back beats, no gaps on either side.
    task automatic test_full_rate();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_text(150);
        tx_idle_pct = 24;
        rx_idle_pct = 24;
    endtask

    // The receiver holds off for a long stretch while characters keep coming,
    // so the result queue fills and the slave side must stall.
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_hold     = 80;
        for (int i = 0; i < 15; i++)
            feed_operator();
        feed_text(".x");
        feed_eot();
        tx_idle_pct = 24;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = 1'b0;
        lex_state = P_NONE;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_byte_extremes();
        test_comment_openers();
        test_periods();
        test_end_of_text();
        test_percent_and_shifts();
        test_random_text(350);
        test_full_rate();
        test_backpressure();
        test_random_text(350);
        feed_eot();

        // Drain what is still owed, then give the block a few more cycles in
        // case it produces anything unexpected.
        while (tokens_due.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
